@@ src/led_matrix_xy_to_index_macros.svh @@
// assertion helpers shared by the rtl
`ifndef LED_MATRIX_XY_TO_INDEX_MACROS_SVH
`define LED_MATRIX_XY_TO_INDEX_MACROS_SVH

// same-cycle implication
`define LMX_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lmx assertion failed");

// next-cycle implication
`define LMX_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lmx assertion failed");

`endif

@@ src/lmx_pkg.sv @@
package lmx_pkg;

   localparam int CFG_DIM_W   = 9;
   localparam int OFFSET_W    = 16;
   localparam int INDEX_W     = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_COLUMNS     = 3'd0,
      CSR_NUM_ROWS        = 3'd1,
      CSR_START_CORNER    = 3'd2,
      CSR_WIRING_VERTICAL = 3'd3,
      CSR_FIRST_ROW_TOP   = 3'd4,
      CSR_INDEX_OFFSET    = 3'd5
   } lmx_csr_type;

   typedef struct packed {
      logic vert;
      logic col_inv;
      logic row_inv;
      logic first_row_top;
   } lmx_mode_type;

   typedef struct packed {
      logic flip_c;
      logic flip_r;
   } lmx_flip_type;

endpackage

@@ src/lmx_front.sv @@
module lmx_front import lmx_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int DIM_W       = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_column,
   input  logic signed [COORD_WIDTH-1:0] in_row,
   input  logic        [DIM_W-1:0]       num_cols,
   input  logic        [DIM_W-1:0]       num_rows,
   input  lmx_mode_type                  mode,
   output logic                          out_valid,
   output logic        [DIM_W-1:0]       out_column,
   output logic        [DIM_W-1:0]       out_row,
   output lmx_flip_type                  out_flip,
   output logic                          busy
);

   // two magnitude bits consumed per remainder stage
   localparam int STAGES = (COORD_WIDTH + 1) / 2;
   localparam int MAG_W  = 2 * STAGES;

   function automatic logic [DIM_W-1:0] rem_step(input logic [DIM_W-1:0] rem,
                                                 input logic b,
                                                 input logic [DIM_W-1:0] n);
      logic [DIM_W:0] t;
      t = {rem, b};
      if (t >= {1'b0, n}) begin
         rem_step = DIM_W'(t - {1'b0, n});
      end else begin
         rem_step = DIM_W'(t);
      end
   endfunction

   function automatic logic [MAG_W-1:0] magnitude(input logic signed [COORD_WIDTH-1:0] v);
      logic [COORD_WIDTH-1:0] u;
      u = v;
      if (v[COORD_WIDTH-1]) begin
         u = ~u + 1'b1;
      end
      magnitude = MAG_W'(u);
   endfunction

   logic [STAGES+1:0] valid_ff, valid_in;
   logic [MAG_W-1:0]  cmag_ff [STAGES+1];
   logic [MAG_W-1:0]  rmag_ff [STAGES+1];
   logic [DIM_W-1:0]  crem_ff [STAGES+1];
   logic [DIM_W-1:0]  rrem_ff [STAGES+1];
   logic [DIM_W-1:0]  crem_in [STAGES+1];
   logic [DIM_W-1:0]  rrem_in [STAGES+1];
   logic [STAGES:0]   cneg_ff, rneg_ff;

   logic [DIM_W-1:0] col_wrap, row_wrap, row_mirr;
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   lmx_flip_type     flip_ff, flip_in;

   assign valid_in = {valid_ff[STAGES:0], in_valid};

   always_comb begin
      crem_in[0] = '0;
      rrem_in[0] = '0;
      for (int k = 0; k < STAGES; k++) begin
         crem_in[k+1] = rem_step(rem_step(crem_ff[k], cmag_ff[k][MAG_W-1-2*k], num_cols),
                                 cmag_ff[k][MAG_W-2-2*k], num_cols);
         rrem_in[k+1] = rem_step(rem_step(rrem_ff[k], rmag_ff[k][MAG_W-1-2*k], num_rows),
                                 rmag_ff[k][MAG_W-2-2*k], num_rows);
      end
   end

   // negative coordinates wrap from the far end
   always_comb begin
      col_wrap = crem_ff[STAGES];
      if (cneg_ff[STAGES] && (crem_ff[STAGES] != '0)) begin
         col_wrap = num_cols - crem_ff[STAGES];
      end
      row_wrap = rrem_ff[STAGES];
      if (rneg_ff[STAGES] && (rrem_ff[STAGES] != '0)) begin
         row_wrap = num_rows - rrem_ff[STAGES];
      end
      row_mirr = row_wrap;
      if (mode.first_row_top) begin
         row_mirr = num_rows - 1'b1 - row_wrap;
      end
      col_in = col_wrap;
      row_in = row_mirr;
      // zigzag: every other run reverses direction
      if (!mode.vert) begin
         flip_in.flip_c = mode.col_inv ^ ~row_mirr[0];
         flip_in.flip_r = mode.row_inv;
      end else begin
         flip_in.flip_c = mode.col_inv;
         flip_in.flip_r = mode.row_inv ^ col_wrap[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      cmag_ff[0] <= magnitude(in_column);
      rmag_ff[0] <= magnitude(in_row);
      cneg_ff[0] <= in_column[COORD_WIDTH-1];
      rneg_ff[0] <= in_row[COORD_WIDTH-1];
      crem_ff[0] <= crem_in[0];
      rrem_ff[0] <= rrem_in[0];
      for (int k = 0; k < STAGES; k++) begin
         cmag_ff[k+1] <= cmag_ff[k];
         rmag_ff[k+1] <= rmag_ff[k];
         cneg_ff[k+1] <= cneg_ff[k];
         rneg_ff[k+1] <= rneg_ff[k];
         crem_ff[k+1] <= crem_in[k+1];
         rrem_ff[k+1] <= rrem_in[k+1];
      end
      col_ff  <= col_in;
      row_ff  <= row_in;
      flip_ff <= flip_in;
   end

   assign out_valid  = valid_ff[STAGES+1];
   assign out_column = col_ff;
   assign out_row    = row_ff;
   assign out_flip   = flip_ff;
   assign busy       = |valid_ff;

endmodule

@@ src/lmx_fifo.sv @@
module lmx_fifo #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));

endmodule

@@ src/lmx_back.sv @@
module lmx_back import lmx_pkg::*; #(
   parameter int DIM_W = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic        [DIM_W-1:0]   in_column,
   input  logic        [DIM_W-1:0]   in_row,
   input  lmx_flip_type              in_flip,
   input  logic        [DIM_W-1:0]   num_cols,
   input  logic        [DIM_W-1:0]   num_rows,
   input  logic                      vert,
   input  logic signed [OFFSET_W-1:0] index_offset,
   output logic                      in_pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [INDEX_W-1:0] out_index
);

   logic [DIM_W-1:0]   col_eff, row_eff, mul_a, mul_b, addend;
   logic [2*DIM_W-1:0] prod;
   logic [INDEX_W-1:0] offset_ext;
   logic               valid_ff, valid_in;
   logic [INDEX_W-1:0] index_ff, index_in;

   always_comb begin
      col_eff = in_flip.flip_c ? (num_cols - 1'b1 - in_column) : in_column;
      row_eff = in_flip.flip_r ? (num_rows - 1'b1 - in_row) : in_row;
      if (vert) begin
         mul_a  = col_eff;
         mul_b  = num_rows;
         addend = row_eff;
      end else begin
         mul_a  = row_eff;
         mul_b  = num_cols;
         addend = col_eff;
      end
      prod       = mul_a * mul_b;
      offset_ext = {{(INDEX_W-OFFSET_W){index_offset[OFFSET_W-1]}}, index_offset};
      index_in   = INDEX_W'(prod) + INDEX_W'(addend) + offset_ext;
   end

   assign in_pop   = in_valid && (!valid_ff || out_ready);
   assign valid_in = in_pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_pop) begin
         index_ff <= index_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_index = index_ff;

endmodule

@@ src/led_matrix_xy_to_index.sv @@
// path: an accepted request goes through the magnitude register, the two-bits-per-stage
// remainder pipeline, the wrap and flip register, the result queue and the output register
// throughput: one request per cycle, sustained while the result side takes one per cycle
// a credit count drops req_ready once STAGES+4 requests (12) sit in the pipeline and queue
// reset: synchronous, clears all control state and returns the configuration registers to their defaults
`include "led_matrix_xy_to_index_macros.svh"

module led_matrix_xy_to_index import lmx_pkg::*; #(
   parameter int MAX_DIM     = 256,
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_column_coord,
   input  logic signed [COORD_WIDTH-1:0] req_row_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [INDEX_W-1:0]     rsp_led_index,
   input  logic                          csr_we,
   input  logic        [CSR_INDEX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int STAGES      = (COORD_WIDTH + 1) / 2;
   localparam int QUEUE_DEPTH = STAGES + 4;
   localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = 2 * DIM_W + $bits(lmx_flip_type);

   logic        [CFG_DIM_W-1:0] num_columns_ff, num_rows_ff;
   logic        [1:0]           start_corner_ff;
   logic                        wiring_vertical_ff, first_row_top_ff;
   logic signed [OFFSET_W-1:0]  index_offset_ff;

   logic [DIM_W-1:0] eff_cols, eff_rows;
   lmx_mode_type     mode;

   logic             front_valid, front_busy;
   logic [DIM_W-1:0] front_col, front_row, queue_col, queue_row;
   lmx_flip_type     front_flip, queue_flip;
   logic [ENTRY_W-1:0] queue_rd;
   logic             fifo_push, fifo_pop, fifo_empty, fifo_full;

   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff     <= CFG_DIM_W'(8);
         num_rows_ff        <= CFG_DIM_W'(8);
         start_corner_ff    <= '0;
         wiring_vertical_ff <= 1'b0;
         first_row_top_ff   <= 1'b0;
         index_offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (lmx_csr_type'(csr_index))
            CSR_NUM_COLUMNS:     num_columns_ff     <= csr_wdata[CFG_DIM_W-1:0];
            CSR_NUM_ROWS:        num_rows_ff        <= csr_wdata[CFG_DIM_W-1:0];
            CSR_START_CORNER:    start_corner_ff    <= csr_wdata[1:0];
            CSR_WIRING_VERTICAL: wiring_vertical_ff <= csr_wdata[0];
            CSR_FIRST_ROW_TOP:   first_row_top_ff   <= csr_wdata[0];
            CSR_INDEX_OFFSET:    index_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // zero size reads as one, oversize saturates
   always_comb begin
      if (num_columns_ff == '0) begin
         eff_cols = DIM_W'(1);
      end else if (32'(num_columns_ff) > 32'(MAX_DIM)) begin
         eff_cols = DIM_W'(MAX_DIM);
      end else begin
         eff_cols = DIM_W'(num_columns_ff);
      end
      if (num_rows_ff == '0) begin
         eff_rows = DIM_W'(1);
      end else if (32'(num_rows_ff) > 32'(MAX_DIM)) begin
         eff_rows = DIM_W'(MAX_DIM);
      end else begin
         eff_rows = DIM_W'(num_rows_ff);
      end
   end

   // base direction from corner, wiring and parity of the effective sizes
   always_comb begin
      mode.vert          = wiring_vertical_ff;
      mode.first_row_top = first_row_top_ff;
      mode.row_inv       = start_corner_ff[1];
      mode.col_inv       = start_corner_ff[0] ^ wiring_vertical_ff;
      if (!eff_cols[0] && wiring_vertical_ff && !start_corner_ff[0]) begin
         mode.row_inv = ~start_corner_ff[1];
      end
      if (!eff_rows[0] && !wiring_vertical_ff && start_corner_ff[1]) begin
         mode.col_inv = ~(start_corner_ff[0] ^ wiring_vertical_ff);
      end
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (credit_ff < CREDIT_W'(QUEUE_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (accept && !fifo_pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (fifo_pop && !accept) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   lmx_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .DIM_W       (DIM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_column  (req_column_coord),
      .in_row     (req_row_coord),
      .num_cols   (eff_cols),
      .num_rows   (eff_rows),
      .mode       (mode),
      .out_valid  (front_valid),
      .out_column (front_col),
      .out_row    (front_row),
      .out_flip   (front_flip),
      .busy       (front_busy)
   );

   assign fifo_push = front_valid;

   lmx_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_data ({front_col, front_row, front_flip}),
      .pop     (fifo_pop),
      .rd_data (queue_rd),
      .empty   (fifo_empty),
      .full    (fifo_full)
   );

   assign {queue_col, queue_row, queue_flip} = queue_rd;

   lmx_back #(
      .DIM_W (DIM_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!fifo_empty),
      .in_column    (queue_col),
      .in_row       (queue_row),
      .in_flip      (queue_flip),
      .num_cols     (eff_cols),
      .num_rows     (eff_rows),
      .vert         (wiring_vertical_ff),
      .index_offset (index_offset_ff),
      .in_pop       (fifo_pop),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_index    (rsp_led_index)
   );

   `LMX_ASSERT_IMPLY(a_push_has_room, clock, reset, fifo_push, !fifo_full)
   `LMX_ASSERT_IMPLY(a_pop_has_data, clock, reset, fifo_pop, !fifo_empty)
   `LMX_ASSERT_NEXT(a_accept_counted, clock, reset, accept, credit_ff != '0)
   `LMX_ASSERT_IMPLY(a_idle_is_empty, clock, reset, credit_ff == '0, fifo_empty && !front_busy)

endmodule
